>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared shorthand for clocked assertions with reset disable
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> src/ccld_pkg.sv
// ---------------------------------------------------------------------------
// ccld_pkg
// shared types, codes and constants of the character canvas line drawer
// ---------------------------------------------------------------------------
package ccld_pkg;

	// canvas size defaults
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// field widths
	localparam int FIELD_W  = 6;
	localparam int CFG_W    = 7;
	localparam int CODE_W   = 3;
	localparam int STATUS_W = 2;
	localparam int CMP_W    = 9;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// register index codes
	localparam logic REG_ROWS_IN_USE = 1'b0;
	localparam logic REG_COLS_IN_USE = 1'b1;

	// item commands
	localparam logic CMD_DRAW = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// cell mark codes
	localparam logic [CODE_W-1:0] CODE_BLANK     = 3'd0;
	localparam logic [CODE_W-1:0] CODE_DASH      = 3'd1;
	localparam logic [CODE_W-1:0] CODE_BAR       = 3'd2;
	localparam logic [CODE_W-1:0] CODE_SLASH     = 3'd3;
	localparam logic [CODE_W-1:0] CODE_BACKSLASH = 3'd4;
	localparam logic [CODE_W-1:0] CODE_PLUS      = 3'd5;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHAPE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_WALK,
		S_FINISH
	} ccld_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic setup;
		logic step;
		logic clear;
		logic finish;
	} ccld_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic reject;
		logic walk_last;
		logic out_free;
	} ccld_stat_t;

endpackage

>>> src/ccld_ctrl.sv
// ---------------------------------------------------------------------------
// ccld_ctrl
// sequencer: clearing pass, item capture, check, cell walk, result hand-off
// ---------------------------------------------------------------------------
module ccld_ctrl
	import ccld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ccld_stat_t stat,
	output ccld_cmd_t  cmd
);

	ccld_state_t state_q;
	ccld_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = stat.reject ? S_FINISH : S_WALK;
			end
			S_WALK: begin
				if (stat.walk_last) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			S_CHECK: begin
				cmd.setup = 1'b1;
			end
			S_WALK: begin
				cmd.step = 1'b1;
			end
			S_FINISH: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> src/ccld_dp.sv
// ---------------------------------------------------------------------------
// ccld_dp
// datapath: item registers, bounds and shape check, cell walker, canvas
// memory with read-modify-write, result register
// ---------------------------------------------------------------------------
module ccld_dp
	import ccld_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ccld_cmd_t           cmd,
	output ccld_stat_t          stat,
	input  logic                cmd_in,
	input  logic [FIELD_W-1:0]  from_row,
	input  logic [FIELD_W-1:0]  from_col,
	input  logic [FIELD_W-1:0]  end_row,
	input  logic [FIELD_W-1:0]  end_col,
	input  logic [CFG_W-1:0]    rows_in_use,
	input  logic [CFG_W-1:0]    cols_in_use,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [CODE_W-1:0]   cell_code
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CMP_W-1:0]  MAXR      = CMP_W'(MAX_ROWS);
	localparam logic [CMP_W-1:0]  MAXC      = CMP_W'(MAX_COLS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	// captured item
	logic               cmd_q;
	logic [FIELD_W-1:0] r1_q, c1_q, r2_q, c2_q;

	// walker
	logic [FIELD_W-1:0]  row_q, col_q, cnt_q;
	logic                row_inc_q, row_dec_q, col_inc_q;
	logic [CODE_W-1:0]   mark_q;
	logic [STATUS_W-1:0] res_q;

	// canvas memory
	logic [CODE_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] addr;
	logic [ADDR_W-1:0] rd_addr_s1;
	logic [CODE_W-1:0] rdata_s1;
	logic              wr_pend_s1;
	logic [CODE_W-1:0] wdata;
	logic [ADDR_W-1:0] clr_q;

	// result register
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [CODE_W-1:0]   out_code_q;

	// check logic
	logic [CMP_W-1:0]    eff_rows, eff_cols;
	logic                oob1, oob2;
	logic                horiz, vert, rdown, cdown, same_dir;
	logic [FIELD_W-1:0]  dr, dc;
	logic [STATUS_W-1:0] res_d;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= cmd_in;
			r1_q  <= from_row;
			c1_q  <= from_col;
			r2_q  <= end_row;
			c2_q  <= end_col;
		end
	end

	// register value capped at the canvas size
	always_comb begin
		eff_rows = (CMP_W'(rows_in_use) > MAXR) ? MAXR : CMP_W'(rows_in_use);
		eff_cols = (CMP_W'(cols_in_use) > MAXC) ? MAXC : CMP_W'(cols_in_use);
		oob1     = (CMP_W'(r1_q) >= eff_rows) || (CMP_W'(c1_q) >= eff_cols);
		oob2     = (CMP_W'(r2_q) >= eff_rows) || (CMP_W'(c2_q) >= eff_cols);
		horiz    = (r1_q == r2_q);
		vert     = (c1_q == c2_q);
		rdown    = (r2_q < r1_q);
		cdown    = (c2_q < c1_q);
		same_dir = (rdown == cdown);
		dr       = rdown ? (r1_q - r2_q) : (r2_q - r1_q);
		dc       = cdown ? (c1_q - c2_q) : (c2_q - c1_q);
		if (cmd_q == CMD_READ) begin
			res_d = oob1 ? ST_BOUNDS : ST_DONE;
		end else if (oob1 || oob2) begin
			res_d = ST_BOUNDS;
		end else if (horiz || vert || (dr == dc)) begin
			res_d = ST_DONE;
		end else begin
			res_d = ST_SHAPE;
		end
	end

	assign addr = ADDR_W'(row_q) * ADDR_W'(MAX_COLS) + ADDR_W'(col_q);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			res_q <= res_d;
			if (cmd_q == CMD_READ) begin
				row_q     <= r1_q;
				col_q     <= c1_q;
				cnt_q     <= '0;
				row_inc_q <= 1'b0;
				row_dec_q <= 1'b0;
				col_inc_q <= 1'b0;
				mark_q    <= CODE_BLANK;
			end else if (horiz) begin
				// a single point lands here too
				row_q     <= r1_q;
				col_q     <= cdown ? c2_q : c1_q;
				cnt_q     <= dc;
				row_inc_q <= 1'b0;
				row_dec_q <= 1'b0;
				col_inc_q <= 1'b1;
				mark_q    <= CODE_DASH;
			end else if (vert) begin
				row_q     <= rdown ? r2_q : r1_q;
				col_q     <= c1_q;
				cnt_q     <= dr;
				row_inc_q <= 1'b1;
				row_dec_q <= 1'b0;
				col_inc_q <= 1'b0;
				mark_q    <= CODE_BAR;
			end else begin
				// diagonal walks from the point with the smaller column
				row_q     <= cdown ? r2_q : r1_q;
				col_q     <= cdown ? c2_q : c1_q;
				cnt_q     <= dc;
				row_inc_q <= same_dir;
				row_dec_q <= !same_dir;
				col_inc_q <= 1'b1;
				mark_q    <= same_dir ? CODE_SLASH : CODE_BACKSLASH;
			end
		end else if (cmd.step) begin
			if (row_inc_q) begin
				row_q <= row_q + FIELD_W'(1);
			end else if (row_dec_q) begin
				row_q <= row_q - FIELD_W'(1);
			end
			if (col_inc_q) col_q <= col_q + FIELD_W'(1);
			cnt_q <= cnt_q - FIELD_W'(1);
		end
	end

	// merge of the new mark into the old cell
	always_comb begin
		if (rdata_s1 == CODE_BLANK) begin
			wdata = mark_q;
		end else if (rdata_s1 != mark_q) begin
			wdata = CODE_PLUS;
		end else begin
			wdata = rdata_s1;
		end
	end

	// one read and one write per cycle; the write trails the read by one cell
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			mem[clr_q] <= CODE_BLANK;
		end else if (wr_pend_s1) begin
			mem[rd_addr_s1] <= wdata;
		end
		if (cmd.step) begin
			rdata_s1   <= mem[addr];
			rd_addr_s1 <= addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_s1 <= 1'b0;
			clr_q      <= '0;
		end else begin
			wr_pend_s1 <= cmd.step && (cmd_q == CMD_DRAW);
			if (cmd.clear) clr_q <= clr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_status_q <= res_q;
			out_code_q   <= ((cmd_q == CMD_READ) && (res_q == ST_DONE)) ? rdata_s1 : CODE_BLANK;
		end
	end

	assign stat.clr_last  = (clr_q == LAST_ADDR);
	assign stat.reject    = (res_d != ST_DONE);
	assign stat.walk_last = (cnt_q == '0);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign cell_code = out_code_q;

endmodule

>>> src/char_canvas_line_draw_top.sv
// ---------------------------------------------------------------------------
// char_canvas_line_draw_top
// character canvas with horizontal, vertical and diagonal line drawing
// ---------------------------------------------------------------------------
// The canvas holds MAX_ROWS x MAX_COLS cells of 3-bit mark codes in one
// single-port-read, single-port-write memory. After reset a clearing pass
// writes every cell blank, one cell per cycle; in_ready stays low during
// it while register writes are taken as usual. The walk of a draw item
// along its line is set by the canvas memory: each cell is a
// read-modify-write, with the read of one cell and the write of the one
// before sharing a cycle. One item is in work at a time; the result sits
// in an output register so the next item can be taken while it waits.
// ---------------------------------------------------------------------------
module char_canvas_line_draw_top
	import ccld_pkg::*;
#(
	parameter int MAX_ROWS = DEF_MAX_ROWS,
	parameter int MAX_COLS = DEF_MAX_COLS
) (
	input  logic                clk,
	input  logic                arst_n,
	// item channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [FIELD_W-1:0]  from_row,
	input  logic [FIELD_W-1:0]  from_col,
	input  logic [FIELD_W-1:0]  end_row,
	input  logic [FIELD_W-1:0]  end_col,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [CODE_W-1:0]   cell_code,
	// register port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	ccld_cmd_t  dp_cmd;
	ccld_stat_t dp_stat;

	// configuration registers
	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic             reg_wr;
	logic             reg_idx;

	// word address picks the register; byte offset bits are don't-care
	assign reg_idx = paddr[PADDR_W-1];
	assign reg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_RESET;
			cols_q <= CFG_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_ROWS_IN_USE: rows_q <= pwdata[CFG_W-1:0];
				REG_COLS_IN_USE: cols_q <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_ROWS_IN_USE: prdata = PDATA_W'(rows_q);
			REG_COLS_IN_USE: prdata = PDATA_W'(cols_q);
			default:         prdata = '0;
		endcase
	end

	// sequencer
	ccld_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (dp_stat),
		.cmd      (dp_cmd)
	);

	// checks, walker, canvas memory and result register
	ccld_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.cmd_in      (cmd),
		.from_row    (from_row),
		.from_col    (from_col),
		.end_row     (end_row),
		.end_col     (end_col),
		.rows_in_use (rows_q),
		.cols_in_use (cols_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.cell_code   (cell_code)
	);

endmodule

>>> src/ccld_checker.sv
// ---------------------------------------------------------------------------
// ccld_checker
// port-level checks of the line drawer, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ccld_checker
	import ccld_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [CODE_W-1:0]   cell_code
);

	// one item in work at a time
	`AST_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// only three status codes exist
	`AST_IMPL(a_status_code, out_valid, status <= ST_BOUNDS)

	// marks run from blank to plus
	`AST_IMPL(a_cell_code, out_valid, cell_code <= CODE_PLUS)

	// a cell code comes only with a finished item
	`AST_IMPL(a_code_done, out_valid && (cell_code != CODE_BLANK), status == ST_DONE)

	// a waiting beat holds
	`AST_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(cell_code))

endmodule

bind char_canvas_line_draw_top ccld_checker u_ccld_checker (.*);
